FILE: src/nns_pkg.sv
// Package for the nearest-neighbor scaler: sizes, item types, register indexes,
// controller states, the controller/datapath command and status groups, helper functions.
// Depends on nothing; every other file of the block uses it.
package nns_pkg;

  // Largest source image the pixel store can hold.
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_SRC_DIM    = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                  MAX_SRC_WIDTH : MAX_SRC_HEIGHT;

  // Pixel store geometry.
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W       = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int ROW_W       = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 16;
  localparam int PIXEL_W  = 32;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 16;
  localparam int BPP_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Effective source size, 1..MAX, and the divider built around it.
  localparam int SIZE_W = $clog2(MAX_SRC_DIM + 1);
  localparam int QUO_W  = (MAX_SRC_DIM > 2) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int PROD_W = COORD_W + 1 + SIZE_W;
  localparam int REM_W  = DST_CFG_W;
  localparam int CNT_W  = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  localparam logic [7:0] BYTE_MASK = 8'hff;

  // Action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [PIXEL_W-1:0] pixel_in;
  } nns_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               status;
  } nns_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD_COL,
    ST_DIV_COL,
    ST_LOAD_ROW,
    ST_DIV_ROW,
    ST_MEM_RD,
    ST_RESPOND
  } nns_state_t;

  // Which result the datapath reports when a beat finishes.
  typedef enum logic [1:0] {
    RES_ERR,
    RES_WRITE,
    RES_READ
  } nns_res_t;

  typedef struct packed {
    logic     load;
    logic     mem_we;
    logic     mem_re;
    logic     div_init;
    logic     div_row;
    logic     div_step;
    logic     save_col;
    logic     finish;
    nns_res_t res_sel;
  } nns_cmd_t;

  typedef struct packed {
    logic is_read;
    logic wr_ok;
    logic rd_ok;
    logic div_last;
  } nns_stat_t;

  // Keep the low 8*bpp bits of a pixel; bpp is clamped to 1..4.
  function automatic logic [PIXEL_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
    logic [BPP_W-1:0]   n;
    logic [PIXEL_W-1:0] m;
    n = bpp;
    if (bpp == '0) n = 3'd1;
    if (bpp > 3'd4) n = 3'd4;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(n)) m = m | (PIXEL_W'(BYTE_MASK) << (8 * i));
    end
    return m;
  endfunction

  // Clamp a configured source size to 1..max_size.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SRC_CFG_W-1:0] raw,
                                                   input int max_size);
    logic [SIZE_W-1:0] s;
    if (raw == '0) begin
      s = SIZE_W'(1);
    end else if (32'(raw) > max_size) begin
      s = SIZE_W'(max_size);
    end else begin
      s = SIZE_W'(raw);
    end
    return s;
  endfunction

endpackage

FILE: src/nearest_neighbor_scaler.sv
// Nearest-neighbor scaler: holds a source image and returns pixels of a scaled image.
// A beat enters when start is high and busy is low; every beat gives exactly one
// result, shown on result for the single cycle in which done is high.
// Action 0 writes pixel_in at source (x_coord, y_coord), masked to bytes_per_pixel
// bytes; action 1 reads destination pixel (x_coord, y_coord). Status 1 marks an
// out-of-range coordinate or an empty destination, with pixel_out zero.
// Configuration: cfg_we writes cfg_data to register cfg_index at once (source width,
// source height, destination width, destination height, bytes per pixel); write it
// only while busy is low and no result is pending.
// Timing: a write or rejected read finishes in the check state. A good read passes
// the check state, then for the column and then the row a multiply (load) state and
// the steps of the shared restoring divider (one quotient bit a step), then a store
// read state and a result state.
// The next beat may be accepted in the cycle that done is high.
// Reset clears the controller and restores the register defaults (256, 256, 256,
// 256, 4); the pixel store is not cleared and a pixel must be written before it is
// read. The receiver cannot stall: each result is offered once.
// Depends on nns_pkg, nns_ctrl and nns_dpath.
module nearest_neighbor_scaler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  nns_pkg::nns_in_t               in_item,
  output logic                           done,
  output nns_pkg::nns_out_t              result,
  input  logic                           cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data
);

  nns_pkg::nns_cmd_t  cmd;
  nns_pkg::nns_stat_t stat;

  nns_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  nns_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

`ifndef SYNTH
  // A result is only strobed once the controller is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobed while busy");

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not start work");

  // Results never come in consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  // An error result carries a zero pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.pixel_out == '0))
    else $error("error result with nonzero pixel");
`endif

endmodule

FILE: src/nns_ctrl.sv
// Controller of the nearest-neighbor scaler: sequences range check, two divisions,
// store access and the result strobe. Depends on nns_pkg.
module nns_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  nns_pkg::nns_stat_t stat,
  output nns_pkg::nns_cmd_t  cmd
);

  nns_pkg::nns_state_t state;
  nns_pkg::nns_state_t state_next;

  // State register and the one-cycle result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nns_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != nns_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      nns_pkg::ST_IDLE: begin
        if (start) state_next = nns_pkg::ST_CHECK;
      end
      nns_pkg::ST_CHECK: begin
        if (stat.is_read && stat.rd_ok) begin
          state_next = nns_pkg::ST_LOAD_COL;
        end else begin
          state_next = nns_pkg::ST_IDLE;
        end
      end
      nns_pkg::ST_LOAD_COL: state_next = nns_pkg::ST_DIV_COL;
      nns_pkg::ST_DIV_COL: begin
        if (stat.div_last) state_next = nns_pkg::ST_LOAD_ROW;
      end
      nns_pkg::ST_LOAD_ROW: state_next = nns_pkg::ST_DIV_ROW;
      nns_pkg::ST_DIV_ROW: begin
        if (stat.div_last) state_next = nns_pkg::ST_MEM_RD;
      end
      nns_pkg::ST_MEM_RD:  state_next = nns_pkg::ST_RESPOND;
      nns_pkg::ST_RESPOND: state_next = nns_pkg::ST_IDLE;
      default:             state_next = nns_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.res_sel = nns_pkg::RES_ERR;
    unique case (state)
      nns_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      nns_pkg::ST_CHECK: begin
        if (!stat.is_read) begin
          // A write finishes here, stored only when in range.
          cmd.mem_we  = stat.wr_ok;
          cmd.finish  = 1'b1;
          cmd.res_sel = stat.wr_ok ? nns_pkg::RES_WRITE : nns_pkg::RES_ERR;
        end else if (!stat.rd_ok) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = nns_pkg::RES_ERR;
        end
      end
      nns_pkg::ST_LOAD_COL: begin
        cmd.div_init = 1'b1;
        cmd.div_row  = 1'b0;
      end
      nns_pkg::ST_DIV_COL: cmd.div_step = 1'b1;
      nns_pkg::ST_LOAD_ROW: begin
        cmd.save_col = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_row  = 1'b1;
      end
      nns_pkg::ST_DIV_ROW: cmd.div_step = 1'b1;
      nns_pkg::ST_MEM_RD:  cmd.mem_re   = 1'b1;
      nns_pkg::ST_RESPOND: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = nns_pkg::RES_READ;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/nns_dpath.sv
// Datapath of the nearest-neighbor scaler: configuration registers, item register,
// coordinate multiplier, restoring divider, pixel store and result register.
// Depends on nns_pkg.
module nns_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  nns_pkg::nns_in_t                    in_item,
  input  nns_pkg::nns_cmd_t                   cmd,
  output nns_pkg::nns_stat_t                  stat,
  output nns_pkg::nns_out_t                   result
);

  // Configuration registers.
  logic [nns_pkg::SRC_CFG_W-1:0] src_width;
  logic [nns_pkg::SRC_CFG_W-1:0] src_height;
  logic [nns_pkg::DST_CFG_W-1:0] dst_width;
  logic [nns_pkg::DST_CFG_W-1:0] dst_height;
  logic [nns_pkg::BPP_W-1:0]     bytes_per_pixel;

  // Current item and the divider.
  nns_pkg::nns_in_t              item;
  logic [nns_pkg::SIZE_W-1:0]    src_w_eff;
  logic [nns_pkg::SIZE_W-1:0]    src_h_eff;
  logic [nns_pkg::COORD_W:0]     mul_a;
  logic [nns_pkg::SIZE_W-1:0]    mul_b;
  logic [nns_pkg::PROD_W-1:0]    product;
  logic                          row_sel;
  logic [nns_pkg::REM_W-1:0]     rem;
  logic [nns_pkg::QUO_W-1:0]     qreg;
  logic [nns_pkg::CNT_W-1:0]     step_cnt;
  logic [nns_pkg::REM_W:0]       rem_sh;
  logic [nns_pkg::REM_W-1:0]     divisor;
  logic                          q_bit;
  logic [nns_pkg::COL_W-1:0]     col_q;
  logic [nns_pkg::ROW_W-1:0]     row_q;

  // Pixel store.
  logic [nns_pkg::PIXEL_W-1:0]   store [nns_pkg::STORE_DEPTH];
  logic [nns_pkg::ADDR_W-1:0]    wr_addr;
  logic [nns_pkg::ADDR_W-1:0]    rd_addr;
  logic [nns_pkg::PIXEL_W-1:0]   rd_data;

  // Register writes from the configuration port; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= nns_pkg::SRC_CFG_W'(256);
      src_height      <= nns_pkg::SRC_CFG_W'(256);
      dst_width       <= nns_pkg::DST_CFG_W'(256);
      dst_height      <= nns_pkg::DST_CFG_W'(256);
      bytes_per_pixel <= nns_pkg::BPP_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nns_pkg::CFG_SRC_WIDTH:  src_width       <= cfg_data[nns_pkg::SRC_CFG_W-1:0];
        nns_pkg::CFG_SRC_HEIGHT: src_height      <= cfg_data[nns_pkg::SRC_CFG_W-1:0];
        nns_pkg::CFG_DST_WIDTH:  dst_width       <= cfg_data[nns_pkg::DST_CFG_W-1:0];
        nns_pkg::CFG_DST_HEIGHT: dst_height      <= cfg_data[nns_pkg::DST_CFG_W-1:0];
        nns_pkg::CFG_BPP:        bytes_per_pixel <= cfg_data[nns_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
  end

  assign src_w_eff = nns_pkg::clamp_size(src_width, nns_pkg::MAX_SRC_WIDTH);
  assign src_h_eff = nns_pkg::clamp_size(src_height, nns_pkg::MAX_SRC_HEIGHT);

  // Range checks for the controller.
  always_comb begin
    stat.is_read  = (item.action == nns_pkg::ACT_READ);
    stat.wr_ok    = (32'(item.x_coord) < 32'(src_w_eff)) &&
                    (32'(item.y_coord) < 32'(src_h_eff));
    stat.rd_ok    = (dst_width != '0) && (dst_height != '0) &&
                    (item.x_coord < dst_width) && (item.y_coord < dst_height);
    stat.div_last = (step_cnt == nns_pkg::CNT_W'(nns_pkg::QUO_W - 1));
  end

  // Numerator (pos+1)*size - 1, formed in the load cycle ahead of the division.
  assign mul_a   = cmd.div_row ? ({1'b0, item.y_coord} + 17'd1)
                               : ({1'b0, item.x_coord} + 17'd1);
  assign mul_b   = cmd.div_row ? src_h_eff : src_w_eff;
  assign product = nns_pkg::PROD_W'(mul_a) * nns_pkg::PROD_W'(mul_b) -
                   nns_pkg::PROD_W'(1);

  // One quotient bit per step. The quotient is below the source size, so only
  // the low QUO_W bits are developed and the upper numerator bits seed the remainder.
  assign divisor = row_sel ? dst_height : dst_width;
  assign rem_sh  = {rem, qreg[nns_pkg::QUO_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      row_sel  <= cmd.div_row;
      rem      <= nns_pkg::REM_W'(product >> nns_pkg::QUO_W);
      qreg     <= nns_pkg::QUO_W'(product);
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= q_bit ? nns_pkg::REM_W'(rem_sh - {1'b0, divisor})
                        : nns_pkg::REM_W'(rem_sh);
      qreg     <= nns_pkg::QUO_W'({qreg, q_bit});
      step_cnt <= step_cnt + nns_pkg::CNT_W'(1);
    end
  end

  // Clamp the finished column quotient to the last source column.
  always_ff @(posedge clk) begin
    if (cmd.save_col) begin
      if (32'(qreg) > 32'(src_w_eff) - 32'd1) begin
        col_q <= nns_pkg::COL_W'(src_w_eff - nns_pkg::SIZE_W'(1));
      end else begin
        col_q <= nns_pkg::COL_W'(qreg);
      end
    end
  end

  // Row quotient clamped the same way.
  always_comb begin
    if (32'(qreg) > 32'(src_h_eff) - 32'd1) begin
      row_q = nns_pkg::ROW_W'(src_h_eff - nns_pkg::SIZE_W'(1));
    end else begin
      row_q = nns_pkg::ROW_W'(qreg);
    end
  end

  // Store addresses: row * MAX_SRC_WIDTH + column.
  assign wr_addr = nns_pkg::ADDR_W'(nns_pkg::ROW_W'(item.y_coord)) *
                   nns_pkg::ADDR_W'(nns_pkg::MAX_SRC_WIDTH) +
                   nns_pkg::ADDR_W'(nns_pkg::COL_W'(item.x_coord));
  assign rd_addr = nns_pkg::ADDR_W'(row_q) * nns_pkg::ADDR_W'(nns_pkg::MAX_SRC_WIDTH) +
                   nns_pkg::ADDR_W'(col_q);

  // Pixel store with separate write and read addresses and registered read data.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      store[wr_addr] <= item.pixel_in & nns_pkg::pixel_mask(bytes_per_pixel);
    end
    if (cmd.mem_re) begin
      rd_data <= store[rd_addr];
    end
  end

  // Result register, loaded when a beat finishes.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (cmd.res_sel)
        nns_pkg::RES_READ: begin
          result.pixel_out <= rd_data;
          result.status    <= 1'b0;
        end
        nns_pkg::RES_WRITE: begin
          result.pixel_out <= '0;
          result.status    <= 1'b0;
        end
        default: begin
          result.pixel_out <= '0;
          result.status    <= 1'b1;
        end
      endcase
    end
  end

endmodule
